>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the vector set block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define VSO_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication.
`define VSO_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `VSO_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define VSO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `VSO_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> hdl/vso_pkg.sv
// Shared constants, codes and controller/datapath command types of the
// vector set block. No dependencies.
`default_nettype none

package vso_pkg;

  localparam int unsigned VECTOR_LENGTH_DEF = 8;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned RESULT_W          = 64;
  localparam int unsigned MODE_W            = 3;
  localparam int unsigned APB_AW            = 3;
  localparam int unsigned APB_DW            = 32;

  localparam logic [MODE_W-1:0] MODE_UNION   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DIFF    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUM     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PRODUCT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INTER   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET   = MODE_UNION;

  typedef enum logic [1:0] {
    OUT_ZERO   = 2'd0,
    OUT_ARITH  = 2'd1,
    OUT_RESULT = 2'd2
  } vso_out_sel_e;

  typedef struct packed {
    logic         xy_we;
    logic         x_re;
    logic         y_re;
    logic         r_re;
    logic         r_we;
    logic         cand_ld;
    logic         cand_from_y;
    logic         arith_ld;
    logic         arith_mul;
    logic         out_ld;
    vso_out_sel_e out_sel;
    logic         out_last;
    logic         out_empty;
  } vso_cmd_t;

  typedef struct packed {
    logic y_match;
    logic r_match;
    logic out_free;
  } vso_status_t;

endpackage

`default_nettype wire

>>> hdl/vso_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vso_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/vso_ctrl.sv
// Sequencer of the vector set block: load counter, loop indices, result
// count and state. Depends on vso_pkg.
`default_nettype none

module vso_ctrl #(
  parameter int unsigned VECTOR_LENGTH = vso_pkg::VECTOR_LENGTH_DEF,
  localparam int unsigned AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1,
  localparam int unsigned RW = $clog2(2 * VECTOR_LENGTH),
  localparam int unsigned CW = $clog2(2 * VECTOR_LENGTH + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [vso_pkg::MODE_W-1:0] mode_i,
  input  wire logic                       s_valid_i,
  output logic                            s_ready_o,
  input  wire vso_pkg::vso_status_t       status_i,
  output vso_pkg::vso_cmd_t               cmd_o,
  output logic      [AW-1:0]              xy_waddr_o,
  output logic      [AW-1:0]              x_raddr_o,
  output logic      [AW-1:0]              y_raddr_o,
  output logic      [RW-1:0]              r_addr_o
);

  import vso_pkg::*;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_AR_RD  = 4'd1;
  localparam logic [3:0] S_AR_EX  = 4'd2;
  localparam logic [3:0] S_AR_OUT = 4'd3;
  localparam logic [3:0] S_C_RD   = 4'd4;
  localparam logic [3:0] S_C_LAT  = 4'd5;
  localparam logic [3:0] S_Y_RD   = 4'd6;
  localparam logic [3:0] S_Y_CMP  = 4'd7;
  localparam logic [3:0] S_D_RD   = 4'd8;
  localparam logic [3:0] S_D_CMP  = 4'd9;
  localparam logic [3:0] S_ADD    = 4'd10;
  localparam logic [3:0] S_O_RD   = 4'd11;
  localparam logic [3:0] S_O_OUT  = 4'd12;
  localparam logic [3:0] S_EMPTY  = 4'd13;

  localparam logic [AW-1:0] LAST_IDX = AW'(VECTOR_LENGTH - 1);

  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     pl_q, pl_d;
  logic [AW-1:0]     i_q, i_d;
  logic [RW-1:0]     j_q, j_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ph_q, ph_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              adv;
  logic              keep;
  logic              j_at_end;

  assign s_ready_o  = (state_q == S_LOAD);
  assign xy_waddr_o = pl_q;
  assign j_at_end   = (CW'(j_q) == (cnt_q - CW'(1)));
  assign keep       = (status_i.y_match == (mode_q == MODE_INTER));

  always_comb begin
    state_d   = state_q;
    pl_d      = pl_q;
    i_d       = i_q;
    j_d       = j_q;
    cnt_d     = cnt_q;
    ph_d      = ph_q;
    mode_d    = mode_q;
    adv       = 1'b0;
    cmd_o     = '0;
    cmd_o.out_sel = OUT_ZERO;
    x_raddr_o = i_q;
    y_raddr_o = i_q;
    r_addr_o  = j_q;

    unique case (state_q)
      S_LOAD: begin
        if (s_valid_i) begin
          cmd_o.xy_we = 1'b1;
          if (pl_q == LAST_IDX) begin
            pl_d   = '0;
            mode_d = mode_i;
            i_d    = '0;
            j_d    = '0;
            cnt_d  = '0;
            ph_d   = 1'b0;
            priority if (mode_i == MODE_SUM || mode_i == MODE_PRODUCT) begin
              state_d = S_AR_RD;
            end else if (mode_i == MODE_UNION || mode_i == MODE_DIFF ||
                         mode_i == MODE_INTER) begin
              state_d = S_C_RD;
            end else begin
              state_d = S_EMPTY;
            end
          end else begin
            pl_d = pl_q + AW'(1);
          end
        end
      end
      S_AR_RD: begin
        cmd_o.x_re = 1'b1;
        cmd_o.y_re = 1'b1;
        state_d    = S_AR_EX;
      end
      S_AR_EX: begin
        cmd_o.arith_ld  = 1'b1;
        cmd_o.arith_mul = (mode_q == MODE_PRODUCT);
        state_d         = S_AR_OUT;
      end
      S_AR_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_sel  = OUT_ARITH;
          cmd_o.out_last = (i_q == LAST_IDX);
          if (i_q == LAST_IDX) begin
            state_d = S_LOAD;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_AR_RD;
          end
        end
      end
      S_C_RD: begin
        cmd_o.x_re = !ph_q;
        cmd_o.y_re = ph_q;
        state_d    = S_C_LAT;
      end
      S_C_LAT: begin
        cmd_o.cand_ld     = 1'b1;
        cmd_o.cand_from_y = ph_q;
        j_d               = '0;
        if (mode_q == MODE_UNION) begin
          state_d = (cnt_q == '0) ? S_ADD : S_D_RD;
        end else begin
          state_d = S_Y_RD;
        end
      end
      S_Y_RD: begin
        cmd_o.y_re = 1'b1;
        y_raddr_o  = j_q[AW-1:0];
        state_d    = S_Y_CMP;
      end
      S_Y_CMP: begin
        if (status_i.y_match || j_q[AW-1:0] == LAST_IDX) begin
          if (keep) begin
            j_d     = '0;
            state_d = (cnt_q == '0) ? S_ADD : S_D_RD;
          end else begin
            adv = 1'b1;
          end
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_Y_RD;
        end
      end
      S_D_RD: begin
        cmd_o.r_re = 1'b1;
        state_d    = S_D_CMP;
      end
      S_D_CMP: begin
        priority if (status_i.r_match) begin
          adv = 1'b1;
        end else if (j_at_end) begin
          state_d = S_ADD;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_D_RD;
        end
      end
      S_ADD: begin
        cmd_o.r_we = 1'b1;
        r_addr_o   = cnt_q[RW-1:0];
        cnt_d      = cnt_q + CW'(1);
        adv        = 1'b1;
      end
      S_O_RD: begin
        cmd_o.r_re = 1'b1;
        state_d    = S_O_OUT;
      end
      S_O_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_sel  = OUT_RESULT;
          cmd_o.out_last = j_at_end;
          if (j_at_end) begin
            state_d = S_LOAD;
          end else begin
            j_d     = j_q + RW'(1);
            state_d = S_O_RD;
          end
        end
      end
      S_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.out_ld    = 1'b1;
          cmd_o.out_sel   = OUT_ZERO;
          cmd_o.out_last  = 1'b1;
          cmd_o.out_empty = 1'b1;
          state_d         = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    // advance to the next candidate, to the Y pass of a union, or on to read-out (or the empty item) once all are done
    if (adv) begin
      if (i_q == LAST_IDX) begin
        if (mode_q == MODE_UNION && !ph_q) begin
          ph_d    = 1'b1;
          i_d     = '0;
          state_d = S_C_RD;
        end else begin
          j_d     = '0;
          state_d = (cnt_d == '0) ? S_EMPTY : S_O_RD;
        end
      end else begin
        i_d     = i_q + AW'(1);
        state_d = S_C_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      pl_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
      ph_q    <= 1'b0;
      mode_q  <= MODE_RESET;
    end else begin
      state_q <= state_d;
      pl_q    <= pl_d;
      i_q     <= i_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
      mode_q  <= mode_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/vso_datapath.sv
// Datapath of the vector set block: X, Y and result stores, candidate
// register, sum/product unit and output register. Depends on vso_pkg, vso_ram.
`default_nettype none

module vso_datapath #(
  parameter int unsigned VECTOR_LENGTH = vso_pkg::VECTOR_LENGTH_DEF,
  localparam int unsigned AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1,
  localparam int unsigned RW = $clog2(2 * VECTOR_LENGTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire vso_pkg::vso_cmd_t            cmd_i,
  output vso_pkg::vso_status_t              status_o,
  input  wire logic [AW-1:0]                xy_waddr_i,
  input  wire logic [AW-1:0]                x_raddr_i,
  input  wire logic [AW-1:0]                y_raddr_i,
  input  wire logic [RW-1:0]                r_addr_i,
  input  wire logic [vso_pkg::DATA_W-1:0]   x_value_i,
  input  wire logic [vso_pkg::DATA_W-1:0]   y_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [vso_pkg::RESULT_W-1:0] out_value_o,
  output logic                              out_last_o,
  output logic                              out_empty_o
);

  import vso_pkg::*;

  logic signed [DATA_W-1:0]   x_rd, y_rd, r_rd;
  logic signed [DATA_W-1:0]   cand_q;
  logic signed [RESULT_W-1:0] arith_q, arith_d;
  logic signed [RESULT_W-1:0] x_ext, y_ext;
  logic signed [RESULT_W-1:0] prod;
  logic        [RESULT_W-1:0] out_value_q, out_value_d;
  logic                       out_valid_q, out_last_q, out_empty_q;

  vso_ram #(.WIDTH(DATA_W), .DEPTH(VECTOR_LENGTH)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.xy_we),
    .waddr_i (xy_waddr_i),
    .wdata_i (x_value_i),
    .re_i    (cmd_i.x_re),
    .raddr_i (x_raddr_i),
    .rdata_o (x_rd)
  );

  vso_ram #(.WIDTH(DATA_W), .DEPTH(VECTOR_LENGTH)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.xy_we),
    .waddr_i (xy_waddr_i),
    .wdata_i (y_value_i),
    .re_i    (cmd_i.y_re),
    .raddr_i (y_raddr_i),
    .rdata_o (y_rd)
  );

  vso_ram #(.WIDTH(DATA_W), .DEPTH(2 * VECTOR_LENGTH)) u_r_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.r_we),
    .waddr_i (r_addr_i),
    .wdata_i (cand_q),
    .re_i    (cmd_i.r_re),
    .raddr_i (r_addr_i),
    .rdata_o (r_rd)
  );

  assign x_ext   = {{(RESULT_W-DATA_W){x_rd[DATA_W-1]}}, x_rd};
  assign y_ext   = {{(RESULT_W-DATA_W){y_rd[DATA_W-1]}}, y_rd};
  // 32x32 signed product; operands are sign-extended in the 64-bit context
  assign prod    = x_rd * y_rd;
  assign arith_d = cmd_i.arith_mul ? prod : (x_ext + y_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cand_ld) begin
      cand_q <= cmd_i.cand_from_y ? y_rd : x_rd;
    end
    if (cmd_i.arith_ld) begin
      arith_q <= arith_d;
    end
  end

  always_comb begin
    unique case (cmd_i.out_sel)
      OUT_ARITH:  out_value_d = arith_q;
      OUT_RESULT: out_value_d = {{(RESULT_W-DATA_W){r_rd[DATA_W-1]}}, r_rd};
      OUT_ZERO:   out_value_d = '0;
      default:    out_value_d = '0;
    endcase
  end

  // output slot: load when empty or being drained in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_value_q <= out_value_d;
      out_last_q  <= cmd_i.out_last;
      out_empty_q <= cmd_i.out_empty;
    end
  end

  assign status_o.y_match  = (y_rd == cand_q);
  assign status_o.r_match  = (r_rd == cand_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;

endmodule

`default_nettype wire

>>> hdl/vector_set_operations.sv
// Vector set operations: loads X/Y pairs, then emits a union, difference,
// intersection, sum or product run. Channels on the input side carry one
// (x, y) pair per transaction in s_axis_tdata; the output side carries one
// result item per transaction, tlast on the final item, tuser set on the
// single item that stands for an empty set (or an unused mode).
// Loading takes one pair per cycle; no result follows until the
// VECTOR_LENGTH-th pair, after which s_axis_tready stays low until the
// final item of the run sits in the output register.
// Sum/product: each item goes through store read, arithmetic register and
// output in turn. Set modes walk single-read-port stores one entry at a time:
// each candidate is fetched, compared against each Y entry (difference,
// intersection) and each result entry already held, then appended if kept;
// read-out reads and emits one result item at a time.
// Reset clears control and the mode register; stores are written before read.
// A stalled receiver pauses the run at the output register; nothing is lost.
// operation_mode sits at APB address 0 and is sampled with the last pair.
// Depends on vso_pkg, vso_ctrl, vso_datapath, vso_ram.
`default_nettype none

module vector_set_operations #(
  parameter int unsigned VECTOR_LENGTH = vso_pkg::VECTOR_LENGTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input pairs
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [2*vso_pkg::DATA_W-1:0] s_axis_tdata,  // x_value, y_value
  // result items
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic      [vso_pkg::RESULT_W-1:0] m_axis_tdata,  // result_value
  output logic                              m_axis_tlast,  // is_last
  output logic                              m_axis_tuser,  // set_empty
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vso_pkg::APB_AW-1:0]   paddr,
  input  wire logic [vso_pkg::APB_DW-1:0]   pwdata,
  output logic      [vso_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  import vso_pkg::*;

  localparam int unsigned AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int unsigned RW = $clog2(2 * VECTOR_LENGTH);

  logic [MODE_W-1:0] mode_q;
  logic              reg_hit;
  vso_cmd_t          cmd;
  vso_status_t       status;
  logic [AW-1:0]     xy_waddr, x_raddr, y_raddr;
  logic [RW-1:0]     r_addr;

  // single register: word index taken from paddr[2]
  assign reg_hit = !paddr[2];
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(APB_DW-MODE_W){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      mode_q <= pwdata[MODE_W-1:0];
    end
  end

  vso_ctrl #(.VECTOR_LENGTH(VECTOR_LENGTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .xy_waddr_o (xy_waddr),
    .x_raddr_o  (x_raddr),
    .y_raddr_o  (y_raddr),
    .r_addr_o   (r_addr)
  );

  vso_datapath #(.VECTOR_LENGTH(VECTOR_LENGTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .xy_waddr_i  (xy_waddr),
    .x_raddr_i   (x_raddr),
    .y_raddr_i   (y_raddr),
    .r_addr_i    (r_addr),
    .x_value_i   (s_axis_tdata[DATA_W-1:0]),
    .y_value_i   (s_axis_tdata[2*DATA_W-1:DATA_W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_empty_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> hdl/vso_checker.sv
// Port-level checks of the vector set block, bound to its top level.
// Depends on vso_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module vso_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [vso_pkg::RESULT_W-1:0] m_axis_tdata,
  input wire logic                         m_axis_tlast,
  input wire logic                         m_axis_tuser,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [vso_pkg::APB_AW-1:0]   paddr,
  input wire logic [vso_pkg::APB_DW-1:0]   pwdata,
  input wire logic [vso_pkg::APB_DW-1:0]   prdata
);

  import vso_pkg::*;

  // hold a stalled result item
  `VSO_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result item changed under stall")

  // an empty-set item is a lone zero closing its run
  `VSO_ASSERT_IMPL(a_empty_item, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "empty item not last or not zero")

  // loading resumes only once the final item of a run is in the output slot
  `VSO_ASSERT_IMPL(a_load_after_run, clk_i, rst_ni, s_axis_tready && m_axis_tvalid, m_axis_tlast, "input taken while a run is unfinished")

  // a written mode reads back on the next cycle
  `VSO_ASSERT_NEXT(a_mode_readback, clk_i, rst_ni, psel && penable && pwrite && !paddr[2], paddr[2] || (prdata[MODE_W-1:0] == $past(pwdata[MODE_W-1:0])), "mode register readback mismatch")

endmodule

bind vector_set_operations vso_checker u_vso_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

`default_nettype wire

>>> dv/vector_set_operations_test.sv
// Self-checking testbench for vector_set_operations: streams (x, y) pairs in,
// predicts each result run and checks it item by item, with random idling.
// Depends on vso_pkg and the vector_set_operations RTL only.
`default_nettype none

module vector_set_operations_test;
  import vso_pkg::*;

  localparam int unsigned       PAIRS         = VECTOR_LENGTH_DEF;
  localparam logic [APB_AW-1:0] MODE_ADDR     = '0;
  localparam logic [MODE_W-1:0] MODE_TOP      = '1;
  localparam int                INT_MIN       = 32'h8000_0000;
  localparam int                INT_MAX       = 32'h7fff_ffff;
  localparam int                SETTLE_CYCLES = 16;
  localparam int                DRAIN_LIMIT   = 20000;
  localparam int                RANDOM_PAIRS  = 136;

  typedef struct {
    logic signed [RESULT_W-1:0] value;
    logic                       last;
    logic                       empty;
  } result_item_t;

  class set_scoreboard;
    logic [MODE_W-1:0] mode;
    int                xs [PAIRS];
    int                ys [PAIRS];
    int                loaded;
    int                distinct [$];
    result_item_t      awaited [$];
    int                errors;

    function new();
      mode   = MODE_RESET;
      loaded = 0;
      errors = 0;
    endfunction

    task report(string what);
      if (errors < 40) $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function void queue_result(logic signed [RESULT_W-1:0] value, logic last, logic empty);
      result_item_t item;
      item.value = value;
      item.last  = last;
      item.empty = empty;
      awaited.push_back(item);
    endfunction

    function bit y_holds(int v);
      foreach (ys[i]) if (ys[i] == v) return 1'b1;
      return 1'b0;
    endfunction

    function void add_distinct(int v);
      foreach (distinct[i]) if (distinct[i] == v) return;
      if (distinct.size() < 2 * PAIRS) distinct.push_back(v);
    endfunction

    function void note_pair(int x, int y);
      longint v;
      xs[loaded] = x;
      ys[loaded] = y;
      loaded++;
      if (loaded < PAIRS) return;
      loaded = 0;

      if (mode == MODE_SUM || mode == MODE_PRODUCT) begin
        for (int i = 0; i < PAIRS; i++) begin
          v = (mode == MODE_SUM) ? longint'(xs[i]) + longint'(ys[i])
                                 : longint'(xs[i]) * longint'(ys[i]);
          queue_result(v, i == PAIRS - 1, 1'b0);
        end
        return;
      end

      distinct.delete();
      if (mode == MODE_UNION) begin
        foreach (xs[i]) add_distinct(xs[i]);
        foreach (ys[i]) add_distinct(ys[i]);
      end else if (mode == MODE_DIFF || mode == MODE_INTER) begin
        foreach (xs[i]) if (y_holds(xs[i]) == (mode == MODE_INTER)) add_distinct(xs[i]);
      end

      // an empty set, or a mode with no meaning, stands as a single flagged item
      if (distinct.size() == 0) begin
        queue_result('0, 1'b1, 1'b1);
      end else begin
        foreach (distinct[k]) queue_result(distinct[k], k == distinct.size() - 1, 1'b0);
      end
    endfunction

    task check_result(logic signed [RESULT_W-1:0] value, logic last, logic empty);
      result_item_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result %0d last %0b empty %0b", value, last, empty));
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value || last !== want.last || empty !== want.empty)
        report($sformatf("result %0d last %0b empty %0b, wanted %0d last %0b empty %0b",
                         value, last, empty, want.value, want.last, want.empty));
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*DATA_W-1:0]   s_axis_tdata  = '0;  // x_value, y_value
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RESULT_W-1:0]   m_axis_tdata;        // result_value
  logic                  m_axis_tlast;        // is_last
  logic                  m_axis_tuser;        // set_empty
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_AW-1:0]     paddr         = '0;
  logic [APB_DW-1:0]     pwdata        = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  set_scoreboard sb;
  int            stall_left = 0;
  int            calm_left  = 0;
  int            roll;
  int            pool [4];

  // product and sum over the corner values, then a disjoint intersection
  logic [MODE_W-1:0] dir_mode [3] = '{MODE_PRODUCT, MODE_SUM, MODE_INTER};
  int dir_x [3*PAIRS] = '{INT_MIN, INT_MAX, INT_MIN, -1, 0, 1, INT_MAX, INT_MIN,
                          INT_MIN, INT_MAX, INT_MIN, -1, 0, INT_MAX, INT_MIN, 32'h5555_5555,
                          1, 2, 3, 4, 5, 6, 7, 8};
  int dir_y [3*PAIRS] = '{INT_MIN, INT_MAX, INT_MAX, -1, INT_MIN, -1, -1, 1,
                          INT_MIN, INT_MAX, INT_MAX, 1, 0, 1, -1, 32'haaaa_aaaa,
                          -1, -2, -3, -4, -5, -6, -7, -8};

  vector_set_operations #(
    .VECTOR_LENGTH(PAIRS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: calm stretches, short stalls and the odd long one
  always @(posedge clk_i) begin
    if (calm_left > 0) begin
      calm_left--;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 31);
      if (roll == 0) begin
        calm_left = $urandom_range(20, 60);
        m_axis_tready <= 1'b1;
      end else if (roll < 8) begin
        stall_left = (roll == 7) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_value(int style);
    case (style)
      0:       return $urandom;
      1:       return pool[$urandom_range(0, 3)];
      2:       return $urandom_range(0, 4) - 2;
      default: begin
        case ($urandom_range(0, 3))
          0:       return INT_MIN;
          1:       return INT_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // write the mode, then read it back
  task automatic write_mode(logic [MODE_W-1:0] m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= APB_DW'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.mode = m;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== APB_DW'(m))
      sb.report($sformatf("mode reads back %0h, wrote %0h", prdata, m));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_pair(int x, int y, int gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pair(x, y);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the sender until every awaited result has come (or DRAIN_LIMIT runs out), then let the block settle
  task automatic drain();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int                sent;
    int                phase;
    int                style;
    int                vectors;
    bit                steady;
    logic [MODE_W-1:0] m;

    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int v = 0; v < 3; v++) begin
      write_mode(dir_mode[v]);
      for (int i = 0; i < PAIRS; i++)
        send_pair(dir_x[v*PAIRS+i], dir_y[v*PAIRS+i], pick_gap(1'b0));
      drain();
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PAIRS) begin
      // sweep every mode value once, then pick mostly meaningful ones
      if (phase <= MODE_TOP) m = MODE_W'(phase);
      else if ($urandom_range(0, 3) != 0) m = MODE_W'($urandom_range(MODE_UNION, MODE_INTER));
      else m = MODE_W'($urandom_range(MODE_INTER + 1, MODE_TOP));
      write_mode(m);
      steady  = ($urandom_range(0, 3) == 0);
      vectors = $urandom_range(1, 2);
      repeat (vectors) begin
        roll  = $urandom_range(0, 9);
        style = (roll < 5) ? 1 : (roll < 7) ? 0 : (roll < 9) ? 2 : 3;
        foreach (pool[k]) pool[k] = $urandom;
        for (int i = 0; i < PAIRS; i++) begin
          send_pair(pick_value(style), pick_value(style), pick_gap(steady));
          sent++;
        end
      end
      drain();
      phase++;
    end

    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(4 * 400_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/vso_pkg.sv
hdl/vso_ram.sv
hdl/vso_ctrl.sv
hdl/vso_datapath.sv
hdl/vector_set_operations.sv
hdl/vso_checker.sv
dv/vector_set_operations_test.sv
